/* rtl/mtecm_pkg.sv */
// Package with payload types, codes and default parameters for the multitouch event mapper.
package mtecm_pkg;

    localparam int MAX_SLOTS_DEF      = 10;
    localparam int SCREEN_WIDTH_DEF   = 1024;
    localparam int SCREEN_HEIGHT_DEF  = 600;
    localparam int REPORT_POINTS_DEF  = 2;
    localparam int COEF_FRAC_BITS_DEF = 16;

    localparam int COORD_W = 10;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 66;

    localparam logic [4:0] TYPE_SYNC = 5'd0;
    localparam logic [4:0] TYPE_KEY  = 5'd1;
    localparam logic [4:0] TYPE_ABS  = 5'd3;

    localparam logic [9:0] CODE_X        = 10'd0;
    localparam logic [9:0] CODE_Y        = 10'd1;
    localparam logic [9:0] CODE_SLOT     = 10'd47;
    localparam logic [9:0] CODE_MT_X     = 10'd53;
    localparam logic [9:0] CODE_MT_Y     = 10'd54;
    localparam logic [9:0] CODE_TRACK    = 10'd57;
    localparam logic [9:0] CODE_TOUCH    = 10'd330;
    localparam logic [9:0] CODE_REPORT   = 10'd0;

    localparam logic [2:0] REG_GXX = 3'd0;
    localparam logic [2:0] REG_GXY = 3'd1;
    localparam logic [2:0] REG_GYX = 3'd2;
    localparam logic [2:0] REG_GYY = 3'd3;
    localparam logic [2:0] REG_OFX = 3'd4;
    localparam logic [2:0] REG_OFY = 3'd5;

    typedef struct packed {
        logic [4:0]        event_type;
        logic [9:0]        event_code;
        logic signed [31:0] event_value;
    } t_in;

    typedef struct packed {
        logic [9:0] report_x;
        logic [9:0] report_y;
        logic       touching;
        logic [1:0] point_count;
        logic [9:0] first_x;
        logic [9:0] first_y;
        logic [9:0] second_x;
        logic [9:0] second_y;
    } t_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg;

    // Request to the serial mapper: one raw point.
    typedef struct packed {
        logic              start;
        logic signed [31:0] raw_x;
        logic signed [31:0] raw_y;
    } t_map_req;

    typedef struct packed {
        logic       done;
        logic [9:0] sx;
        logic [9:0] sy;
    } t_map_rsp;

endpackage

/* rtl/mtecm_mapper.sv */
// Bit-serial affine mapper: shift-add products, saturation, rounding and clamping.
module mtecm_mapper #(
    parameter int COEF_FRAC_BITS = mtecm_pkg::COEF_FRAC_BITS_DEF,
    parameter int SCREEN_WIDTH   = mtecm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT  = mtecm_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mtecm_pkg::t_map_req  i_req,
    input  logic signed [31:0]   i_gxx,
    input  logic signed [31:0]   i_gxy,
    input  logic signed [31:0]   i_gyx,
    input  logic signed [31:0]   i_gyy,
    input  logic signed [31:0]   i_ofx,
    input  logic signed [31:0]   i_ofy,
    output mtecm_pkg::t_map_rsp  o_rsp
);
    import mtecm_pkg::*;

    localparam logic signed [ACC_W-1:0] LIM_MAX = ACC_W'(64'sh7FFF_FFFF_FFFF_FFFF);
    localparam logic signed [ACC_W-1:0] LIM_MIN = -LIM_MAX - ACC_W'(1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [5:0]               r_cnt, n_cnt;
    logic [31:0]              r_rx, n_rx;
    logic [31:0]              r_ry, n_ry;
    logic signed [ACC_W-1:0]  r_ax, n_ax;
    logic signed [ACC_W-1:0]  r_ay, n_ay;
    logic                     r_done, n_done;
    logic [9:0]               r_sx, n_sx;
    logic [9:0]               r_sy, n_sy;
    logic signed [ACC_W-1:0]  w_tx, w_ty;

    // Each cycle one bit of both raw values adds its partial products.
    // The top bit carries negative weight (two's complement).
    function automatic logic signed [ACC_W-1:0] f_term(input logic bit_x,
        input logic bit_y, input logic signed [31:0] gx, input logic signed [31:0] gy,
        input logic [5:0] pos);
        logic signed [ACC_W-1:0] s;
        s = '0;
        if (bit_x) s = s + (ACC_W'(gx) <<< pos);
        if (bit_y) s = s + (ACC_W'(gy) <<< pos);
        if (pos == 6'd31) s = -s;
        return s;
    endfunction

    function automatic logic [9:0] f_round(input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] ofs, input int maxv);
        logic signed [ACC_W-1:0] v;
        logic signed [ACC_W-1:0] r;
        v = a + ofs;
        if (v > LIM_MAX) v = LIM_MAX;
        if (v < LIM_MIN) v = LIM_MIN;
        if (v < 0) return '0;
        if (v >= (ACC_W'(maxv) <<< COEF_FRAC_BITS)) return 10'(maxv);
        r = (v + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        if (r > ACC_W'(maxv)) return 10'(maxv);
        return 10'(r);
    endfunction

    always_comb begin
        w_tx = f_term(r_rx[0], r_ry[0], i_gxx, i_gxy, r_cnt);
        w_ty = f_term(r_rx[0], r_ry[0], i_gyx, i_gyy, r_cnt);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_done  = 1'b0;
        n_sx    = r_sx;
        n_sy    = r_sy;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_rx    = i_req.raw_x;
                    n_ry    = i_req.raw_y;
                    n_ax    = '0;
                    n_ay    = '0;
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_ax  = r_ax + w_tx;
                n_ay  = r_ay + w_ty;
                n_rx  = r_rx >> 1;
                n_ry  = r_ry >> 1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) n_state = S_FIN;
            end
            S_FIN: begin
                n_sx    = f_round(r_ax, ACC_W'(i_ofx), SCREEN_WIDTH - 1);
                n_sy    = f_round(r_ay, ACC_W'(i_ofy), SCREEN_HEIGHT - 1);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_ax <= n_ax;
        r_ay <= n_ay;
        r_sx <= n_sx;
        r_sy <= n_sy;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sx   = r_sx;
    assign o_rsp.sy   = r_sy;

endmodule

/* rtl/multitouch_event_calibrated_mapper.sv */
// Top level of the multitouch event mapper: slot tracking, report sequencing and output.
// A report sync with events pending walks the slots one per cycle, pausing while a
// complete slot is mapped, and hands each complete slot, up to REPORT_POINTS of them,
// to the bit-serial mapper; with no complete slot the last raw point is mapped instead.
// The mapper answers each request with a done strobe. The result waits in an output
// register; the next event is taken once the result is handed over.
module multitouch_event_calibrated_mapper #(
    parameter int MAX_SLOTS      = mtecm_pkg::MAX_SLOTS_DEF,
    parameter int SCREEN_WIDTH   = mtecm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT  = mtecm_pkg::SCREEN_HEIGHT_DEF,
    parameter int REPORT_POINTS  = mtecm_pkg::REPORT_POINTS_DEF,
    parameter int COEF_FRAC_BITS = mtecm_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mtecm_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output mtecm_pkg::t_out o_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  mtecm_pkg::t_cfg i_cfg
);
    import mtecm_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MAP  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_flags [MAX_SLOTS];
    logic [31:0]        r_sx_raw [MAX_SLOTS];
    logic [31:0]        r_sy_raw [MAX_SLOTS];
    logic [3:0]         r_cur;
    logic [31:0]        r_lx, r_ly;
    logic               r_touch, r_pend;
    logic signed [31:0] r_gxx, r_gxy, r_gyx, r_gyy, r_ofx, r_ofy;
    logic [SLOT_W-1:0]  r_idx;
    logic [1:0]         r_cnt;
    logic               r_last;
    logic [9:0]         r_px [2];
    logic [9:0]         r_py [2];
    logic               r_ovalid;
    t_out               r_out;
    t_map_req           w_req;
    t_map_rsp           w_rsp;
    logic [SLOT_W-1:0]  w_cs;
    logic               w_acc;
    logic               w_scan_end;

    mtecm_mapper #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_map (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .i_gxx  (r_gxx),
        .i_gxy  (r_gxy),
        .i_gyx  (r_gyx),
        .i_gyy  (r_gyy),
        .i_ofx  (r_ofx),
        .i_ofy  (r_ofy),
        .o_rsp  (w_rsp)
    );

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign w_acc       = i_valid && o_ready;
    assign w_cs        = (32'(r_cur) < MAX_SLOTS) ? SLOT_W'(r_cur) : '0;
    assign w_scan_end  = (32'(r_idx) == MAX_SLOTS - 1);

    always_comb begin
        w_req.start = 1'b0;
        w_req.raw_x = r_last ? r_lx : r_sx_raw[r_idx];
        w_req.raw_y = r_last ? r_ly : r_sy_raw[r_idx];
        if (r_state == S_MAP) w_req.start = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_data.event_type == TYPE_SYNC
                    && i_data.event_code == CODE_REPORT && r_pend)
                    n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_flags[r_idx] == 3'b111) n_state = S_MAP;
                else if (w_scan_end) n_state = (r_cnt == 2'd0) ? S_MAP : S_OUT;
            end
            S_MAP:  n_state = S_WAIT;
            S_WAIT: begin
                if (w_rsp.done) begin
                    if (r_last || 32'(r_cnt) + 1 >= REPORT_POINTS || w_scan_end)
                        n_state = S_OUT;
                    else n_state = S_SCAN;
                end
            end
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_lx     <= '0;
            r_ly     <= '0;
            r_touch  <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_gxx    <= 32'sd65536;
            r_gxy    <= '0;
            r_gyx    <= '0;
            r_gyy    <= 32'sd65536;
            r_ofx    <= '0;
            r_ofy    <= '0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_flags[k]  <= '0;
                r_sx_raw[k] <= '0;
                r_sy_raw[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg.index)
                    REG_GXX: r_gxx <= i_cfg.data;
                    REG_GXY: r_gxy <= i_cfg.data;
                    REG_GYX: r_gyx <= i_cfg.data;
                    REG_GYY: r_gyy <= i_cfg.data;
                    REG_OFX: r_ofx <= i_cfg.data;
                    REG_OFY: r_ofy <= i_cfg.data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_data.event_type == TYPE_ABS) begin
                            case (i_data.event_code)
                                CODE_SLOT: begin
                                    if (i_data.event_value >= 0
                                        && i_data.event_value < MAX_SLOTS)
                                        r_cur <= 4'(i_data.event_value);
                                end
                                CODE_X, CODE_MT_X: begin
                                    r_lx <= i_data.event_value;
                                    r_pend <= 1'b1;
                                    if (i_data.event_code == CODE_MT_X) begin
                                        r_sx_raw[w_cs] <= i_data.event_value;
                                        r_flags[w_cs] <= r_flags[w_cs] | 3'b011;
                                    end else begin
                                        r_sx_raw[0] <= i_data.event_value;
                                        r_flags[0] <= r_flags[0] | 3'b010;
                                    end
                                end
                                CODE_Y, CODE_MT_Y: begin
                                    r_ly <= i_data.event_value;
                                    r_pend <= 1'b1;
                                    if (i_data.event_code == CODE_MT_Y) begin
                                        r_sy_raw[w_cs] <= i_data.event_value;
                                        r_flags[w_cs] <= r_flags[w_cs] | 3'b101;
                                    end else begin
                                        r_sy_raw[0] <= i_data.event_value;
                                        r_flags[0] <= r_flags[0] | 3'b100;
                                    end
                                end
                                CODE_TRACK: begin
                                    r_pend <= 1'b1;
                                    if (i_data.event_value < 0) begin
                                        r_flags[w_cs]  <= '0;
                                        r_sx_raw[w_cs] <= '0;
                                        r_sy_raw[w_cs] <= '0;
                                    end else begin
                                        r_flags[w_cs] <= r_flags[w_cs] | 3'b001;
                                    end
                                end
                                default: ;
                            endcase
                        end else if (i_data.event_type == TYPE_KEY
                                     && i_data.event_code == CODE_TOUCH) begin
                            r_pend  <= 1'b1;
                            r_touch <= (i_data.event_value != 0);
                            if (i_data.event_value == 0) begin
                                r_cur <= '0;
                                for (int k = 0; k < MAX_SLOTS; k++) begin
                                    r_flags[k]  <= '0;
                                    r_sx_raw[k] <= '0;
                                    r_sy_raw[k] <= '0;
                                end
                            end
                        end else if (n_state == S_SCAN) begin
                            r_idx  <= '0;
                            r_cnt  <= '0;
                            r_last <= 1'b0;
                            if (r_touch && r_flags[0] == 3'b110) r_flags[0] <= 3'b111;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_flags[r_idx] != 3'b111) begin
                        if (w_scan_end) r_last <= (r_cnt == 2'd0);
                        else r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                S_WAIT: begin
                    if (w_rsp.done && !r_last) begin
                        r_px[r_cnt[0]] <= w_rsp.sx;
                        r_py[r_cnt[0]] <= w_rsp.sy;
                        r_cnt <= r_cnt + 2'd1;
                        if (!w_scan_end) r_idx <= r_idx + SLOT_W'(1);
                    end
                    if (w_rsp.done && r_last) begin
                        r_px[0] <= w_rsp.sx;
                        r_py[0] <= w_rsp.sy;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_pend   <= 1'b0;
                    r_touch  <= (r_cnt != 2'd0);
                    r_out.touching    <= (r_cnt != 2'd0);
                    r_out.point_count <= r_cnt;
                    r_out.first_x     <= (r_cnt != 2'd0) ? r_px[0] : '0;
                    r_out.first_y     <= (r_cnt != 2'd0) ? r_py[0] : '0;
                    r_out.second_x    <= (r_cnt == 2'd2) ? r_px[1] : '0;
                    r_out.second_y    <= (r_cnt == 2'd2) ? r_py[1] : '0;
                    if (r_cnt == 2'd2) begin
                        r_out.report_x <= 10'((11'(r_px[0]) + 11'(r_px[1])) >> 1);
                        r_out.report_y <= 10'((11'(r_py[0]) + 11'(r_py[1])) >> 1);
                    end else begin
                        r_out.report_x <= r_px[0];
                        r_out.report_y <= r_py[0];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/mtecm_checker.sv */
// Port-level checker for the multitouch event mapper, bound to the top level.
module mtecm_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input mtecm_pkg::t_out o_data
);
    import mtecm_pkg::*;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.point_count != 2'd3)) else $error("bad point count");

    a_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.touching == (o_data.point_count != 2'd0)))
        else $error("touching disagrees with count");

    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.point_count == 2'd0) |->
        (o_data.first_x == '0 && o_data.second_x == '0)) else $error("absent point set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data))) else $error("result dropped");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result waits");

endmodule

bind multitouch_event_calibrated_mapper mtecm_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);

/* verif/mtecm_checker.sv */
// Checker for the multitouch event mapper: channel monitor, state predictor and result compare.
`timescale 1ns / 100ps
module mtecm_scoreboard (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  mtecm_pkg::t_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  mtecm_pkg::t_out i_out_data,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  mtecm_pkg::t_cfg i_cfg,
    output int              o_fail_count,
    output int              o_outstanding
);
    import mtecm_pkg::*;

    localparam int NSLOT = MAX_SLOTS_DEF;
    localparam int FRAC = COEF_FRAC_BITS_DEF;
    localparam logic [2:0] F_ACTIVE = 3'b001;
    localparam logic [2:0] F_HAVE_X = 3'b010;
    localparam logic [2:0] F_HAVE_Y = 3'b100;
    localparam logic [2:0] F_COMPLETE = 3'b111;
    localparam longint LMAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint LMIN = -64'sh7fff_ffff_ffff_ffff - 1;

    longint     coef [6];
    logic [2:0] slot_flags [NSLOT];
    longint     slot_x [NSLOT];
    longint     slot_y [NSLOT];
    int         cur_slot;
    longint     last_x;
    longint     last_y;
    bit         touch_down;
    bit         pending;
    t_out       expected_reports [$];
    int         fails;

    assign o_fail_count = fails;
    assign o_outstanding = expected_reports.size();

    function automatic longint sat_add(longint a, longint b);
        if (b > 0 && a > LMAX - b) return LMAX;
        if (b < 0 && a < LMIN - b) return LMIN;
        return a + b;
    endfunction

    function automatic int to_screen(longint v, int maxv);
        longint lim;
        lim = longint'(maxv) <<< FRAC;
        if (v < 0) return 0;
        if (v >= lim) return maxv;
        v = (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    task automatic calibrate(input longint rx, input longint ry, output int sx, output int sy);
        sx = to_screen(sat_add(sat_add(rx * coef[REG_GXX], ry * coef[REG_GXY]), coef[REG_OFX]),
                       SCREEN_WIDTH_DEF - 1);
        sy = to_screen(sat_add(sat_add(rx * coef[REG_GYX], ry * coef[REG_GYY]), coef[REG_OFY]),
                       SCREEN_HEIGHT_DEF - 1);
    endtask

    task automatic clear_all();
        for (int i = 0; i < NSLOT; i++) begin
            slot_flags[i] = '0;
            slot_x[i] = 0;
            slot_y[i] = 0;
        end
        cur_slot = 0;
    endtask

    task automatic track_event(input t_in ev);
        longint v;
        int s;
        int px [2];
        int py [2];
        int cnt;
        int sx;
        int sy;
        t_out r;
        v = longint'(ev.event_value);
        px = '{0, 0};
        py = '{0, 0};
        cnt = 0;
        if (ev.event_type == TYPE_ABS) begin
            if (ev.event_code == CODE_SLOT) begin
                if (v >= 0 && v < NSLOT) cur_slot = int'(v);
            end else if (ev.event_code == CODE_X || ev.event_code == CODE_MT_X) begin
                s = (ev.event_code == CODE_MT_X) ? cur_slot : 0;
                last_x = v;
                pending = 1;
                slot_x[s] = v;
                slot_flags[s] |= F_HAVE_X;
                if (ev.event_code == CODE_MT_X) slot_flags[s] |= F_ACTIVE;
            end else if (ev.event_code == CODE_Y || ev.event_code == CODE_MT_Y) begin
                s = (ev.event_code == CODE_MT_Y) ? cur_slot : 0;
                last_y = v;
                pending = 1;
                slot_y[s] = v;
                slot_flags[s] |= F_HAVE_Y;
                if (ev.event_code == CODE_MT_Y) slot_flags[s] |= F_ACTIVE;
            end else if (ev.event_code == CODE_TRACK) begin
                pending = 1;
                if (v < 0) begin
                    slot_flags[cur_slot] = '0;
                    slot_x[cur_slot] = 0;
                    slot_y[cur_slot] = 0;
                end else begin
                    slot_flags[cur_slot] |= F_ACTIVE;
                end
            end
            return;
        end
        if (ev.event_type == TYPE_KEY && ev.event_code == CODE_TOUCH) begin
            touch_down = (v != 0);
            if (!touch_down) clear_all();
            pending = 1;
            return;
        end
        if (!(ev.event_type == TYPE_SYNC && ev.event_code == CODE_REPORT && pending)) return;
        if (touch_down && !slot_flags[0][0] && slot_flags[0][2:1] == 2'b11)
            slot_flags[0] |= F_ACTIVE;
        for (int i = 0; i < NSLOT && cnt < REPORT_POINTS_DEF; i++) begin
            if (slot_flags[i] == F_COMPLETE) begin
                calibrate(slot_x[i], slot_y[i], px[cnt], py[cnt]);
                cnt++;
            end
        end
        if (cnt >= 2) begin
            sx = (px[0] + px[1]) / 2;
            sy = (py[0] + py[1]) / 2;
            touch_down = 1;
        end else if (cnt == 1) begin
            sx = px[0];
            sy = py[0];
            touch_down = 1;
        end else begin
            touch_down = 0;
            calibrate(last_x, last_y, sx, sy);
        end
        pending = 0;
        r.report_x = sx[9:0];
        r.report_y = sy[9:0];
        r.touching = touch_down;
        r.point_count = cnt[1:0];
        r.first_x = px[0][9:0];
        r.first_y = py[0][9:0];
        r.second_x = px[1][9:0];
        r.second_y = py[1][9:0];
        expected_reports.push_back(r);
    endtask

    function automatic void cmp_field(string nm, int e, int a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
            fails++;
        end
    endfunction

    initial begin
        fails = 0;
        coef = '{64'sd65536, 0, 0, 64'sd65536, 0, 0};
        clear_all();
        last_x = 0;
        last_y = 0;
        touch_down = 0;
        pending = 0;
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual %h", $time,
                             i_out_data);
                    fails++;
                end else begin
                    e = expected_reports.pop_front();
                    cmp_field("report_x", e.report_x, i_out_data.report_x);
                    cmp_field("report_y", e.report_y, i_out_data.report_y);
                    cmp_field("touching", e.touching, i_out_data.touching);
                    cmp_field("point_count", e.point_count, i_out_data.point_count);
                    cmp_field("first_x", e.first_x, i_out_data.first_x);
                    cmp_field("first_y", e.first_y, i_out_data.first_y);
                    cmp_field("second_x", e.second_x, i_out_data.second_x);
                    cmp_field("second_y", e.second_y, i_out_data.second_y);
                end
            end
            if (i_cfg_valid && i_cfg_ready && i_cfg.index <= REG_OFY)
                coef[i_cfg.index] = longint'(signed'(i_cfg.data));
            if (i_in_valid && i_in_ready) track_event(i_in_data);
        end
    end

endmodule

/* verif/testbench.sv */
// Testbench top for the multitouch event mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
    import mtecm_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_cfg i_cfg;
    int   fail_count;
    int   outstanding;
    int   sent;
    int   hold_request;
    bit   calm;
    int   quiet_cycles;

    multitouch_event_calibrated_mapper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg(i_cfg)
    );

    mtecm_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg(i_cfg),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver counts its own long hold-off when one is requested.
    initial begin
        int hold;
        hold = 0;
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                i_ready = 0;
                hold--;
            end else begin
                i_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(input logic [4:0] ty, input logic [9:0] cd, input logic [31:0] v);
        if (!calm) begin
            while ($urandom_range(0, 99) < 33) begin
                i_valid = 0;
                @(negedge i_clk);
            end
        end
        i_valid = 1;
        i_data = '{event_type: ty, event_code: cd, event_value: v};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 0;
        sent++;
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        i_cfg_valid = 1;
        i_cfg = '{index: idx, data: v};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic write_coefs(input logic [31:0] gxx, input logic [31:0] gxy,
                               input logic [31:0] gyx, input logic [31:0] gyy,
                               input logic [31:0] ofx, input logic [31:0] ofy);
        wait_drained();
        write_reg(REG_GXX, gxx);
        write_reg(REG_GXY, gxy);
        write_reg(REG_GYX, gyx);
        write_reg(REG_GYY, gyy);
        write_reg(REG_OFX, ofx);
        write_reg(REG_OFY, ofy);
    endtask

    function automatic logic [31:0] coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 1300);
    endfunction

    task automatic touch_frame();
        int n;
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) send(TYPE_KEY, CODE_TOUCH, 1);
        for (int k = 0; k < n; k++) begin
            send(TYPE_ABS, CODE_SLOT, $urandom_range(0, 9));
            if ($urandom_range(0, 9) < 8) send(TYPE_ABS, CODE_TRACK, $urandom_range(0, 900));
            if ($urandom_range(0, 9) < 9) send(TYPE_ABS, CODE_MT_X, coord());
            if ($urandom_range(0, 9) < 9) send(TYPE_ABS, CODE_MT_Y, coord());
            if ($urandom_range(0, 9) == 0) send(TYPE_ABS, CODE_TRACK, -1);
        end
        if ($urandom_range(0, 5) == 0) begin
            send(TYPE_ABS, CODE_X, coord());
            send(TYPE_ABS, CODE_Y, coord());
        end
        if ($urandom_range(0, 7) == 0) send(TYPE_KEY, CODE_TOUCH, 0);
        send(TYPE_SYNC, CODE_REPORT, 0);
    endtask

    task automatic random_phase(input int items);
        int start;
        start = sent;
        while (sent - start < items) begin
            if ($urandom_range(0, 99) < 85)
                touch_frame();
            else
                send(5'($urandom), 10'($urandom), $urandom);
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        i_cfg_valid = 0;
        i_cfg = '0;
        sent = 0;
        hold_request = 0;
        calm = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send(TYPE_ABS, CODE_X, 32'h7fff_ffff);
        send(TYPE_ABS, CODE_Y, 32'h8000_0000);
        send(TYPE_SYNC, CODE_REPORT, 0);
        send(TYPE_SYNC, CODE_REPORT, 0);
        send(TYPE_KEY, CODE_TOUCH, 1);
        send(TYPE_ABS, CODE_X, 100);
        send(TYPE_ABS, CODE_Y, 200);
        send(TYPE_SYNC, CODE_REPORT, 0);
        send(TYPE_ABS, CODE_SLOT, 32'hffff_ffff);
        send(TYPE_ABS, CODE_SLOT, 10);
        send(TYPE_ABS, CODE_SLOT, 9);
        send(TYPE_ABS, CODE_TRACK, 5);
        send(TYPE_ABS, CODE_MT_X, 1023);
        send(TYPE_ABS, CODE_MT_Y, 599);
        send(TYPE_ABS, 10'd48, 7);
        send(TYPE_SYNC, 10'd2, 0);
        send(TYPE_KEY, 10'd331, 0);
        send(5'd31, 10'd1023, 32'hffff_ffff);
        send(TYPE_SYNC, CODE_REPORT, 0);
        send(TYPE_ABS, CODE_TRACK, 32'hffff_ffff);
        send(TYPE_SYNC, CODE_REPORT, 0);
        send(TYPE_KEY, CODE_TOUCH, 0);
        send(TYPE_SYNC, CODE_REPORT, 0);
        random_phase(250);

        write_coefs(32'h0000_c000, 32'h0000_1000, 32'hffff_f800, 32'h0000_8000,
                    32'h0014_0000, 32'hfffb_0000);
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        random_phase(150);
        hold_request = 400;
        random_phase(150);

        write_coefs(0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0000_8000, 32'hffff_8000);
        calm = 1;
        random_phase(300);
        calm = 0;

        write_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h8000_0000);
        random_phase(150);
        wait_drained();
        random_phase(150);

        write_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(300);

        write_coefs($urandom_range(0, 32'h20000) - 32'h10000, $urandom_range(0, 32'h4000),
                    $urandom_range(0, 32'h4000), $urandom_range(0, 32'h20000) - 32'h8000,
                    $urandom, $urandom);
        random_phase(300);

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
